FILE: sv/tsm_pkg.sv
// tsm_pkg: shared types, constants and helper functions of the texture sampler
// used by every module of the sampler except tsm_ram; depends on nothing else

package tsm_pkg;

    localparam int TEXEL_WORDS   = 8192;
    localparam int MAX_SIZE_LOG2 = 6;
    localparam int COMPONENTS    = 4;

    localparam int ADDR_W  = $clog2(TEXEL_WORDS);
    localparam int TEXEL_W = 64;
    localparam int COMP_W  = 16;
    localparam int COORD_W = 16 + MAX_SIZE_LOG2;
    localparam int WGT_W   = 17;
    localparam int WP_W    = 2 * WGT_W;
    localparam int ACC_W   = COMP_W + WP_W + 2;
    localparam int D_W     = 16 + MAX_SIZE_LOG2;
    localparam int SQ_W    = 2 * D_W - 1;
    localparam int SUM_W   = SQ_W + 1;
    localparam int LOD_BIT = 24;
    localparam int TAPS    = 4;

    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        WRAP_REPEAT = 2'd0,
        WRAP_MIRROR = 2'd1,
        WRAP_EDGE   = 2'd2,
        WRAP_BORDER = 2'd3
    } t_wrap;

    typedef enum logic [2:0] {
        CFG_MINIFY_FILTER  = 3'd0,
        CFG_MAGNIFY_FILTER = 3'd1,
        CFG_WRAP_H         = 3'd2,
        CFG_WRAP_V         = 3'd3,
        CFG_BORDER_COLOR   = 3'd4,
        CFG_BASE_WIDTH     = 3'd5,
        CFG_BASE_HEIGHT    = 3'd6,
        CFG_LEVEL_COUNT    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               minify_filter;
        logic               magnify_filter;
        t_wrap              wrap_horizontal;
        t_wrap              wrap_vertical;
        logic [TEXEL_W-1:0] border_color;
        logic [2:0]         base_width_log2;
        logic [2:0]         base_height_log2;
        logic [2:0]         level_count;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic [12:0]        write_address;
        logic [63:0]        write_data;
        logic signed [23:0] s_coord;
        logic signed [23:0] t_coord;
        logic               has_derivatives;
        logic signed [15:0] ds_dx;
        logic signed [15:0] dt_dx;
        logic signed [15:0] ds_dy;
        logic signed [15:0] dt_dy;
    } t_in_item;

    typedef struct packed {
        logic [15:0] comp_red;
        logic [15:0] comp_green;
        logic [15:0] comp_blue;
        logic [15:0] comp_alpha;
        logic [2:0]  level_used;
        logic        minified;
    } t_out_item;

    typedef struct packed {
        logic               mode;
        logic [12:0]        write_address;
        logic [63:0]        write_data;
        logic signed [23:0] s_coord;
        logic signed [23:0] t_coord;
        logic [2:0]         level;
        logic               minified;
        logic               bilinear;
    } t_lod_item;

    typedef struct packed {
        logic                          mode;
        logic [12:0]                   write_address;
        logic [63:0]                   write_data;
        logic [2:0]                    level;
        logic                          minified;
        logic                          bilinear;
        logic [TAPS-1:0][ADDR_W-1:0]   addr;
        logic [TAPS-1:0]               border;
        logic [WGT_W-1:0]              w_lft;
        logic [WGT_W-1:0]              w_rgt;
        logic [WGT_W-1:0]              w_top;
        logic [WGT_W-1:0]              w_bot;
    } t_tap_req;

    typedef struct packed {
        logic [COORD_W-1:0] coord;
        logic               oob;
        logic               inv;
    } t_map;

    function automatic logic [2:0] clamp_log2(logic [2:0] v);
        return (v > 3'(MAX_SIZE_LOG2)) ? 3'(MAX_SIZE_LOG2) : v;
    endfunction

    function automatic logic [2:0] level_log2(logic [2:0] base, logic [2:0] lvl);
        return (base > lvl) ? (base - lvl) : 3'd0;
    endfunction

    // word offset of a level: levels are packed one after another
    function automatic logic [ADDR_W-1:0] level_offset(logic [2:0] bw, logic [2:0] bh,
                                                        logic [2:0] lvl);
        logic [ADDR_W+1:0] acc;
        logic [3:0]        sh;
        acc = '0;
        for (int k = 0; k < MAX_SIZE_LOG2; k++) begin
            sh = {1'b0, level_log2(bw, 3'(k))} + {1'b0, level_log2(bh, 3'(k))};
            if (3'(k) < lvl) begin
                acc = acc + ((ADDR_W+2)'(1) << sh);
            end
        end
        return acc[ADDR_W-1:0];
    endfunction

    function automatic t_map map_coord(logic signed [24:0] raw, logic [2:0] lsz, t_wrap wrap);
        t_map        m;
        logic [24:0] neg;
        logic [24:0] shl;
        logic [5:0]  top;
        neg   = -raw;
        shl   = raw << lsz;
        top   = (6'd1 << lsz) - 6'd1;
        m.oob = 1'b0;
        m.inv = 1'b0;
        if (wrap == WRAP_REPEAT || (wrap == WRAP_MIRROR && !raw[16])) begin
            m.coord = COORD_W'(raw[15:0]) << lsz;
        end else if (wrap == WRAP_MIRROR) begin
            m.inv   = 1'b1;
            m.coord = COORD_W'(neg[15:0]) << lsz;
        end else if (raw[24]) begin
            m.oob   = 1'b1;
            m.coord = COORD_W'(shl[15:0]);
        end else if (raw[23:16] != 8'd0) begin
            m.oob   = 1'b1;
            m.coord = COORD_W'({top, shl[15:0]});
        end else begin
            m.coord = COORD_W'(raw[15:0]) << lsz;
        end
        return m;
    endfunction

    function automatic logic [ADDR_W-1:0] tap_addr(logic [ADDR_W-1:0] off, logic [2:0] wl,
                                                    logic [COORD_W-1:0] cx,
                                                    logic [COORD_W-1:0] cy);
        return off + (ADDR_W'(cy[COORD_W-1:16]) << wl) + ADDR_W'(cx[COORD_W-1:16]);
    endfunction

endpackage

FILE: sv/tsm_ram.sv
// tsm_ram: generic single-port synchronous ram with registered read
// no dependencies

module tsm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

FILE: sv/tsm_lod.sv
// tsm_lod: input register, footprint squares and level-of-detail selection
// depends on tsm_pkg

module tsm_lod import tsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_lod_item o_item,
    input  logic      i_ready
);

    logic                  r1_v;
    t_in_item              r1_item;
    logic [3:0][SQ_W-1:0]  r1_sq;
    logic [3:0][SQ_W-1:0]  n1_sq;
    logic                  r2_v;
    t_lod_item             r2_item;
    t_lod_item             n2_item;
    logic                  s1_free;
    logic                  s2_free;
    logic [2:0]            bw;
    logic [2:0]            bh;
    logic signed [D_W-1:0] dv [4];
    logic signed [2*D_W-1:0] prod [4];
    logic [SUM_W-1:0]      lx;
    logic [SUM_W-1:0]      ly;
    logic [SUM_W-1:0]      m;
    logic [2:0]            cnt;
    logic [2:0]            last_lvl;
    logic                  minify;

    assign s2_free = !r2_v || i_ready;
    assign s1_free = !r1_v || s2_free;
    assign o_stall = !s1_free;
    assign o_valid = r2_v;
    assign o_item  = r2_item;

    // derivatives scaled by the base size are shifts, then squared
    always_comb begin
        bw    = clamp_log2(i_cfg.base_width_log2);
        bh    = clamp_log2(i_cfg.base_height_log2);
        dv[0] = D_W'(i_item.ds_dx) <<< bw;
        dv[1] = D_W'(i_item.dt_dx) <<< bh;
        dv[2] = D_W'(i_item.ds_dy) <<< bw;
        dv[3] = D_W'(i_item.dt_dy) <<< bh;
        for (int i = 0; i < 4; i++) begin
            prod[i]  = dv[i] * dv[i];
            n1_sq[i] = prod[i][SQ_W-1:0];
        end
    end

    // level = count of even bit positions above the threshold, then clamp
    always_comb begin
        lx       = {1'b0, r1_sq[0]} + {1'b0, r1_sq[1]};
        ly       = {1'b0, r1_sq[2]} + {1'b0, r1_sq[3]};
        m        = (lx > ly) ? lx : ly;
        minify   = r1_item.has_derivatives && ((m >> LOD_BIT) != '0);
        cnt      = 3'd0;
        for (int k = 1; k <= MAX_SIZE_LOG2; k++) begin
            if ((m >> (LOD_BIT + 2 * k)) != '0) begin
                cnt = cnt + 3'd1;
            end
        end
        last_lvl = (i_cfg.level_count == 3'd0) ? 3'd0 : (i_cfg.level_count - 3'd1);
        n2_item.mode          = r1_item.mode;
        n2_item.write_address = r1_item.write_address;
        n2_item.write_data    = r1_item.write_data;
        n2_item.s_coord       = r1_item.s_coord;
        n2_item.t_coord       = r1_item.t_coord;
        n2_item.minified      = minify;
        n2_item.level         = !minify ? 3'd0 : ((cnt > last_lvl) ? last_lvl : cnt);
        n2_item.bilinear      = minify ? i_cfg.minify_filter : i_cfg.magnify_filter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (s1_free) begin
                r1_v <= i_valid;
            end
            if (s2_free) begin
                r2_v <= r1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r1_item <= i_item;
            r1_sq   <= n1_sq;
        end
        if (s2_free && r1_v) begin
            r2_item <= n2_item;
        end
    end

endmodule

FILE: sv/tsm_map.sv
// tsm_map: coordinate wrap rules, tap addresses, border flags and axis weights
// depends on tsm_pkg

module tsm_map import tsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_lod_item i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_tap_req  o_req,
    input  logic      i_ready
);

    logic              r_v;
    t_tap_req          r_req;
    t_tap_req          n_req;
    logic              s_free;
    logic [2:0]        bw;
    logic [2:0]        bh;
    logic [2:0]        wl;
    logic [2:0]        hl;
    logic [ADDR_W-1:0] off;
    logic [WGT_W-1:0]  hx;
    logic [WGT_W-1:0]  hy;
    logic signed [24:0] hxs;
    logic signed [24:0] hys;
    logic signed [24:0] rs0;
    logic signed [24:0] rs1;
    logic signed [24:0] rt0;
    logic signed [24:0] rt1;
    t_map              mx0;
    t_map              mx1;
    t_map              my0;
    t_map              my1;
    logic              bdr_h;
    logic              bdr_v;

    assign s_free  = !r_v || i_ready;
    assign o_ready = s_free;
    assign o_valid = r_v;
    assign o_req   = r_req;

    always_comb begin
        bw    = clamp_log2(i_cfg.base_width_log2);
        bh    = clamp_log2(i_cfg.base_height_log2);
        wl    = level_log2(bw, i_item.level);
        hl    = level_log2(bh, i_item.level);
        off   = level_offset(bw, bh, i_item.level);
        // half a texel of this level
        hx    = ONE_Q16 >> ({1'b0, wl} + 4'd1);
        hy    = ONE_Q16 >> ({1'b0, hl} + 4'd1);
        hxs   = signed'(25'(hx));
        hys   = signed'(25'(hy));
        rs0   = i_item.bilinear ? (25'(i_item.s_coord) - hxs) : 25'(i_item.s_coord);
        rt0   = i_item.bilinear ? (25'(i_item.t_coord) - hys) : 25'(i_item.t_coord);
        rs1   = 25'(i_item.s_coord) + hxs;
        rt1   = 25'(i_item.t_coord) + hys;
        mx0   = map_coord(rs0, wl, i_cfg.wrap_horizontal);
        mx1   = map_coord(rs1, wl, i_cfg.wrap_horizontal);
        my0   = map_coord(rt0, hl, i_cfg.wrap_vertical);
        my1   = map_coord(rt1, hl, i_cfg.wrap_vertical);
        bdr_h = i_cfg.wrap_horizontal == WRAP_BORDER;
        bdr_v = i_cfg.wrap_vertical == WRAP_BORDER;

        n_req.mode          = i_item.mode;
        n_req.write_address = i_item.write_address;
        n_req.write_data    = i_item.write_data;
        n_req.level         = i_item.level;
        n_req.minified      = i_item.minified;
        n_req.bilinear      = i_item.bilinear;
        // tap order: top-left, top-right, bottom-right, bottom-left
        n_req.addr[0]   = tap_addr(off, wl, mx0.coord, my0.coord);
        n_req.addr[1]   = tap_addr(off, wl, mx1.coord, my0.coord);
        n_req.addr[2]   = tap_addr(off, wl, mx1.coord, my1.coord);
        n_req.addr[3]   = tap_addr(off, wl, mx0.coord, my1.coord);
        n_req.border[0] = (bdr_h && mx0.oob) || (bdr_v && my0.oob);
        n_req.border[1] = (bdr_h && mx1.oob) || (bdr_v && my0.oob);
        n_req.border[2] = (bdr_h && mx1.oob) || (bdr_v && my1.oob);
        n_req.border[3] = (bdr_h && mx0.oob) || (bdr_v && my1.oob);
        n_req.w_lft = mx0.inv ? {1'b0, mx0.coord[15:0]} : (ONE_Q16 - {1'b0, mx0.coord[15:0]});
        n_req.w_top = my0.inv ? {1'b0, my0.coord[15:0]} : (ONE_Q16 - {1'b0, my0.coord[15:0]});
        n_req.w_rgt = mx1.inv ? (ONE_Q16 - {1'b0, mx1.coord[15:0]}) : {1'b0, mx1.coord[15:0]};
        n_req.w_bot = my1.inv ? (ONE_Q16 - {1'b0, my1.coord[15:0]}) : {1'b0, my1.coord[15:0]};
        // nearest reads the first tap at full weight
        if (!i_item.bilinear) begin
            n_req.w_lft = ONE_Q16;
            n_req.w_top = ONE_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (s_free) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_free && i_valid) begin
            r_req <= n_req;
        end
    end

endmodule

FILE: sv/tsm_filter.sv
// tsm_filter: tap sequencer over the texel ram, weighted accumulation and
// output register; depends on tsm_pkg and tsm_ram

module tsm_filter import tsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_tap_req  i_req,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_result,
    input  logic      i_stall
);

    logic                    r4_v;
    t_tap_req                r4_req;
    logic [1:0]              r_tap;
    logic                    r5_v;
    logic                    r5_first;
    logic                    r5_last;
    logic                    r5_border;
    logic [WP_W-1:0]         r5_w;
    logic [2:0]              r5_level;
    logic                    r5_min;
    logic [3:0][ACC_W-1:0]   r_acc;
    logic [3:0][ACC_W-1:0]   n_acc;
    logic                    r_done_v;
    logic [2:0]              r_done_level;
    logic                    r_done_min;
    logic                    r_out_v;
    t_out_item               r_out;
    t_out_item               n_out;
    logic                    adv;
    logic                    issue;
    logic                    last;
    logic                    s4_free;
    logic [ADDR_W-1:0]       t_addr;
    logic                    t_border;
    logic [WGT_W-1:0]        wa;
    logic [WGT_W-1:0]        wb;
    logic                    ram_we;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_addr;
    logic [TEXEL_W-1:0]      rdata;
    logic [TEXEL_W-1:0]      tdata;
    logic [3:0][15:0]        sat;

    assign adv     = !r_out_v || !i_stall;
    assign issue   = r4_v && adv;
    assign last    = (r4_req.mode == MODE_WRITE) || !r4_req.bilinear || (r_tap == 2'd3);
    assign s4_free = !r4_v || (adv && last);
    assign o_ready = s4_free;
    assign o_valid = r_out_v;
    assign o_result = r_out;

    always_comb begin
        unique case (r_tap)
            2'd0: begin
                t_addr = r4_req.addr[0]; t_border = r4_req.border[0];
                wa = r4_req.w_lft; wb = r4_req.w_top;
            end
            2'd1: begin
                t_addr = r4_req.addr[1]; t_border = r4_req.border[1];
                wa = r4_req.w_rgt; wb = r4_req.w_top;
            end
            2'd2: begin
                t_addr = r4_req.addr[2]; t_border = r4_req.border[2];
                wa = r4_req.w_rgt; wb = r4_req.w_bot;
            end
            default: begin
                t_addr = r4_req.addr[3]; t_border = r4_req.border[3];
                wa = r4_req.w_lft; wb = r4_req.w_bot;
            end
        endcase
    end

    // writes and reads share the one port in arrival order
    assign ram_we   = issue && (r4_req.mode == MODE_WRITE);
    assign ram_re   = issue && (r4_req.mode == MODE_SAMPLE) && !t_border;
    assign ram_addr = (r4_req.mode == MODE_WRITE) ? ADDR_W'(r4_req.write_address) : t_addr;

    tsm_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (TEXEL_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r4_req.write_data),
        .o_rdata (rdata)
    );

    always_comb begin
        tdata = r5_border ? i_cfg.border_color : rdata;
        for (int c = 0; c < 4; c++) begin
            n_acc[c] = (r5_first ? '0 : r_acc[c])
                     + ACC_W'(tdata[COMP_W*c +: COMP_W] * r5_w);
            sat[c]   = (r_acc[c][ACC_W-1:32] > (ACC_W-32)'(16'hFFFF)) ? 16'hFFFF
                                                                    : r_acc[c][47:32];
            if (c >= COMPONENTS) begin
                sat[c] = 16'd0;
            end
        end
        n_out.comp_red   = sat[0];
        n_out.comp_green = sat[1];
        n_out.comp_blue  = sat[2];
        n_out.comp_alpha = sat[3];
        n_out.level_used = r_done_level;
        n_out.minified   = r_done_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v     <= 1'b0;
            r_tap    <= 2'd0;
            r5_v     <= 1'b0;
            r_done_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (s4_free) begin
                r4_v <= i_valid;
            end
            if (issue) begin
                r_tap <= last ? 2'd0 : (r_tap + 2'd1);
            end
            if (adv) begin
                r5_v     <= issue && (r4_req.mode == MODE_SAMPLE);
                r_done_v <= r5_v && r5_last;
                r_out_v  <= r_done_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_free && i_valid) begin
            r4_req <= i_req;
        end
        if (issue) begin
            r5_first  <= r_tap == 2'd0;
            r5_last   <= last;
            r5_border <= t_border;
            r5_w      <= wa * wb;
            r5_level  <= r4_req.level;
            r5_min    <= r4_req.minified;
        end
        if (adv && r5_v) begin
            r_acc <= n_acc;
        end
        if (adv && r5_v && r5_last) begin
            r_done_level <= r5_level;
            r_done_min   <= r5_min;
        end
        if (adv && r_done_v) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: sv/texture_sampler_2d_mip_wrap.sv
// texture_sampler_2d_mip_wrap: top level with configuration registers
// depends on tsm_pkg, tsm_lod, tsm_map, tsm_filter

// Mipmapped 2D texture sampler. A write transaction stores one 64-bit texel word and
// produces no result; a sample transaction produces one filtered texel. All texel
// accesses go through one single-port texel ram, one access per cycle while the output
// is not stalled: writes and nearest samples use one access slot each, bilinear samples
// one slot per tap, taken in turn, and transactions of either kind can follow each
// other back to back. Texel memory has no reset and needs no clearing: every word
// must be written before it is sampled. Configuration may only change while the
// sampler is idle.

module texture_sampler_2d_mip_wrap import tsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      lod_v;
    t_lod_item lod_item;
    logic      map_ready;
    logic      map_v;
    t_tap_req  map_req;
    logic      flt_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.minify_filter    <= 1'b0;
            r_cfg.magnify_filter   <= 1'b0;
            r_cfg.wrap_horizontal  <= WRAP_REPEAT;
            r_cfg.wrap_vertical    <= WRAP_REPEAT;
            r_cfg.border_color     <= '0;
            r_cfg.base_width_log2  <= 3'd6;
            r_cfg.base_height_log2 <= 3'd6;
            r_cfg.level_count      <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MINIFY_FILTER:  r_cfg.minify_filter    <= i_cfg_data[0];
                CFG_MAGNIFY_FILTER: r_cfg.magnify_filter   <= i_cfg_data[0];
                CFG_WRAP_H:         r_cfg.wrap_horizontal  <= t_wrap'(i_cfg_data[1:0]);
                CFG_WRAP_V:         r_cfg.wrap_vertical    <= t_wrap'(i_cfg_data[1:0]);
                CFG_BORDER_COLOR:   r_cfg.border_color     <= i_cfg_data;
                CFG_BASE_WIDTH:     r_cfg.base_width_log2  <= i_cfg_data[2:0];
                CFG_BASE_HEIGHT:    r_cfg.base_height_log2 <= i_cfg_data[2:0];
                CFG_LEVEL_COUNT:    r_cfg.level_count      <= i_cfg_data[2:0];
            endcase
        end
    end

    tsm_lod u_lod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (lod_v),
        .o_item  (lod_item),
        .i_ready (map_ready)
    );

    tsm_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (lod_v),
        .i_item  (lod_item),
        .o_ready (map_ready),
        .o_valid (map_v),
        .o_req   (map_req),
        .i_ready (flt_ready)
    );

    tsm_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (map_v),
        .i_req    (map_req),
        .o_ready  (flt_ready),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall)
    );

endmodule

FILE: sv/tsm_checker.sv
// tsm_checker: port-level assertions for the texture sampler and their bind
// depends on tsm_pkg and texture_sampler_2d_mip_wrap

module tsm_checker import tsm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_result
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result))
        else $error("stalled result changed");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.level_used <= 3'(MAX_SIZE_LOG2))
        else $error("level out of range");

    a_mag_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.minified |-> o_result.level_used == 3'd0)
        else $error("magnified sample not at level zero");

endmodule

bind texture_sampler_2d_mip_wrap tsm_checker u_tsm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
